FILE: design/swsr_pkg.sv
`default_nettype none

package swsr_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);
    localparam int TICK_W        = 16;
    localparam int DELAY_W       = 8;
    localparam int FRAME_W       = 4;
    localparam int BYTE_CNT_W    = 3;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 16;

    localparam logic [FRAME_W-1:0] MAX_FRAME_BYTES = FRAME_W'(8);

    localparam logic [CFG_IDX_W-1:0] REG_START_LOW    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START_HIGH   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES  = CFG_IDX_W'(3);

    localparam logic [TICK_W-1:0]  RST_START_LOW    = TICK_W'(18000);
    localparam logic [TICK_W-1:0]  RST_START_HIGH   = TICK_W'(20);
    localparam logic [DELAY_W-1:0] RST_SAMPLE_DELAY = DELAY_W'(30);
    localparam logic [FRAME_W-1:0] RST_FRAME_BYTES  = FRAME_W'(5);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_LO = 4'd1,
        PH_START_HI = 4'd2,
        PH_RESP_A   = 4'd3,
        PH_RESP_B   = 4'd4,
        PH_RESP_C   = 4'd5,
        PH_BIT_RISE = 4'd6,
        PH_BIT_WAIT = 4'd7,
        PH_BIT_FALL = 4'd8
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0]  start_low_ticks;
        logic [TICK_W-1:0]  start_high_ticks;
        logic [DELAY_W-1:0] sample_delay_ticks;
        logic [FRAME_W-1:0] bytes_per_frame;
    } cfg_t;

    typedef struct packed {
        logic                     drive_enable;
        logic                     drive_level;
        logic                     byte_valid;
        logic [BITS_PER_BYTE-1:0] data_byte;
        logic                     last_byte;
        logic                     busy_res;
    } result_t;

endpackage

`default_nettype wire

FILE: design/single_wire_sensor_reader_top.sv
`default_nettype none

// Host side of a single-wire humidity sensor link. Every input beat is one
// one-microsecond sample tick (start_req, line_level) and yields exactly one
// result beat carrying the line drive controls, an optional received byte
// with its end-of-frame flag, and the busy flag. One beat is taken per clock:
// the phase sequencer and the output register both load at the edge that
// accepts a beat, so its result is offered from the next cycle on, and
// in_ready stays high while that register is empty or being drained, so
// throughput is one tick per cycle unless out_ready holds it. Configuration
// (start pulse lengths, sample delay, bytes per frame) must be written through
// the cfg port only while no reading is in progress; the block does not
// enforce this. Writes to unknown indexes are dropped.
module single_wire_sensor_reader_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output wire logic                            in_ready,
    input  wire logic                            start_req,
    input  wire logic                            line_level,
    output wire logic                            out_valid,
    input  wire logic                            out_ready,
    output wire logic                            drive_enable,
    output wire logic                            drive_level,
    output wire logic                            byte_valid,
    output wire logic [swsr_pkg::BITS_PER_BYTE-1:0] data_byte,
    output wire logic                            last_byte,
    output wire logic                            busy_res,
    input  wire logic                            cfg_valid,
    output wire logic                            cfg_ready,
    input  wire logic [swsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [swsr_pkg::CFG_DATA_W-1:0] cfg_data
);

    swsr_pkg::cfg_t    cfg;
    swsr_pkg::result_t result;
    swsr_pkg::result_t res_reg;
    logic              out_valid_reg, out_valid_next;
    logic              step;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;

    swsr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    swsr_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .start_req  (start_req),
        .line_level (line_level),
        .cfg        (cfg),
        .result     (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= result;
    end

    assign out_valid    = out_valid_reg;
    assign drive_enable = res_reg.drive_enable;
    assign drive_level  = res_reg.drive_level;
    assign byte_valid   = res_reg.byte_valid;
    assign data_byte    = res_reg.data_byte;
    assign last_byte    = res_reg.last_byte;
    assign busy_res     = res_reg.busy_res;

    a_last_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_byte |-> byte_valid)
        else $error("last_byte without byte_valid");

    a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_byte |-> !busy_res)
        else $error("frame end left the reader busy");

    a_drive_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_enable |-> busy_res && !byte_valid)
        else $error("line driven outside the start pulse");

    a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> data_byte == '0 && !last_byte)
        else $error("byte fields set without byte_valid");

    a_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted tick produced no result");

endmodule

`default_nettype wire

FILE: design/swsr_cfg.sv
`default_nettype none

module swsr_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [swsr_pkg::CFG_IDX_W-1:0]     wr_index,
    input  wire logic [swsr_pkg::CFG_DATA_W-1:0]    wr_data,
    output swsr_pkg::cfg_t                          cfg
);

    swsr_pkg::cfg_t cfg_reg;
    swsr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                swsr_pkg::REG_START_LOW:
                    cfg_next.start_low_ticks = wr_data[swsr_pkg::TICK_W-1:0];
                swsr_pkg::REG_START_HIGH:
                    cfg_next.start_high_ticks = wr_data[swsr_pkg::TICK_W-1:0];
                swsr_pkg::REG_SAMPLE_DELAY:
                    cfg_next.sample_delay_ticks = wr_data[swsr_pkg::DELAY_W-1:0];
                swsr_pkg::REG_FRAME_BYTES:
                    cfg_next.bytes_per_frame = wr_data[swsr_pkg::FRAME_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks    <= swsr_pkg::RST_START_LOW;
            cfg_reg.start_high_ticks   <= swsr_pkg::RST_START_HIGH;
            cfg_reg.sample_delay_ticks <= swsr_pkg::RST_SAMPLE_DELAY;
            cfg_reg.bytes_per_frame    <= swsr_pkg::RST_FRAME_BYTES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: design/swsr_fsm.sv
`default_nettype none

module swsr_fsm (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic       start_req,
    input  wire logic       line_level,
    input  wire swsr_pkg::cfg_t cfg,
    output swsr_pkg::result_t result
);

    localparam int TW = swsr_pkg::TICK_W;
    localparam int BW = swsr_pkg::BIT_CNT_W;
    localparam int CW = swsr_pkg::BYTE_CNT_W;
    localparam int FW = swsr_pkg::FRAME_W;
    localparam int DW = swsr_pkg::BITS_PER_BYTE;

    swsr_pkg::phase_t phase_reg, phase_next;
    logic [TW-1:0]    tick_reg, tick_next;
    logic [BW-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]    byte_cnt_reg, byte_cnt_next;
    logic [DW-1:0]    shift_reg, shift_next;

    logic [TW-1:0] tick_inc;
    logic [FW-1:0] frame_len;
    logic          frame_done;
    logic          byte_fire;

    assign tick_inc = tick_reg + TW'(1);

    // frame length clamped to 1..8
    always_comb
    begin
        if (cfg.bytes_per_frame == FW'(0))
            frame_len = FW'(1);
        else if (cfg.bytes_per_frame > swsr_pkg::MAX_FRAME_BYTES)
            frame_len = swsr_pkg::MAX_FRAME_BYTES;
        else
            frame_len = cfg.bytes_per_frame;
    end

    assign frame_done = ((FW'(byte_cnt_reg) + FW'(1)) >= frame_len);
    assign byte_fire  = (phase_reg == swsr_pkg::PH_BIT_FALL) && !line_level
                        && (bit_cnt_reg == BW'(0));

    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_cnt_next  = bit_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        shift_next    = shift_reg;
        case (phase_reg)
            swsr_pkg::PH_IDLE:
            begin
                if (start_req)
                begin
                    // request tick is already the first low tick
                    phase_next    = swsr_pkg::PH_START_LO;
                    tick_next     = TW'(1);
                    bit_cnt_next  = '0;
                    byte_cnt_next = '0;
                    shift_next    = '0;
                end
            end
            swsr_pkg::PH_START_LO:
            begin
                if (tick_reg >= cfg.start_low_ticks)
                begin
                    phase_next = swsr_pkg::PH_START_HI;
                    tick_next  = TW'(1);
                end
                else
                    tick_next = tick_inc;
            end
            swsr_pkg::PH_START_HI:
            begin
                if (tick_reg >= cfg.start_high_ticks)
                begin
                    phase_next = swsr_pkg::PH_RESP_A;
                    tick_next  = '0;
                end
                else
                    tick_next = tick_inc;
            end
            swsr_pkg::PH_RESP_A:
            begin
                if (!line_level)
                    phase_next = swsr_pkg::PH_RESP_B;
            end
            swsr_pkg::PH_RESP_B:
            begin
                if (line_level)
                    phase_next = swsr_pkg::PH_RESP_C;
            end
            swsr_pkg::PH_RESP_C:
            begin
                if (!line_level)
                    phase_next = swsr_pkg::PH_BIT_RISE;
            end
            swsr_pkg::PH_BIT_RISE:
            begin
                if (line_level)
                begin
                    phase_next = swsr_pkg::PH_BIT_WAIT;
                    tick_next  = '0;
                end
            end
            swsr_pkg::PH_BIT_WAIT:
            begin
                tick_next = tick_inc;
                if (tick_inc >= TW'(cfg.sample_delay_ticks))
                begin
                    shift_next   = {shift_reg[DW-2:0], line_level};
                    bit_cnt_next = bit_cnt_reg + BW'(1);
                    phase_next   = swsr_pkg::PH_BIT_FALL;
                end
            end
            swsr_pkg::PH_BIT_FALL:
            begin
                if (!line_level)
                begin
                    phase_next = swsr_pkg::PH_BIT_RISE;
                    if (bit_cnt_reg == BW'(0))
                    begin
                        shift_next = '0;
                        if (frame_done)
                        begin
                            byte_cnt_next = '0;
                            phase_next    = swsr_pkg::PH_IDLE;
                        end
                        else
                            byte_cnt_next = byte_cnt_reg + CW'(1);
                    end
                end
            end
            default:
                phase_next = swsr_pkg::PH_IDLE;
        endcase
    end

    // outputs reflect the phase reached at the end of the tick
    always_comb
    begin
        result.drive_enable = (phase_next == swsr_pkg::PH_START_LO)
                              || (phase_next == swsr_pkg::PH_START_HI);
        result.drive_level  = (phase_next == swsr_pkg::PH_START_HI);
        result.byte_valid   = byte_fire;
        result.data_byte    = byte_fire ? shift_reg : '0;
        result.last_byte    = byte_fire && frame_done;
        result.busy_res     = (phase_next != swsr_pkg::PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= swsr_pkg::PH_IDLE;
            tick_reg     <= '0;
            bit_cnt_reg  <= '0;
            byte_cnt_reg <= '0;
            shift_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_cnt_reg  <= bit_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
            shift_reg    <= shift_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W  = swsr_pkg::CFG_IDX_W;
    localparam int DATA_W = swsr_pkg::CFG_DATA_W;
    localparam int TK_W   = swsr_pkg::TICK_W;
    localparam int BYTE_W = swsr_pkg::BITS_PER_BYTE;

    typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_ready;
    logic start_req = 1'b0;
    logic line_level = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic drive_enable;
    logic drive_level;
    logic byte_valid;
    logic [BYTE_W-1:0] data_byte;
    logic last_byte;
    logic busy_res;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    // link model state and its copy of the registers
    swsr_pkg::cfg_t link_cfg;
    swsr_pkg::phase_t link_phase;
    logic [TK_W-1:0] link_ticks;
    logic [swsr_pkg::BIT_CNT_W-1:0] link_bits;
    logic [swsr_pkg::BYTE_CNT_W-1:0] link_bytes;
    logic [BYTE_W-1:0] link_shift;

    swsr_pkg::result_t pending_results[$];
    swsr_pkg::result_t got_beat;
    swsr_pkg::result_t want_beat;
    int mismatches = 0;
    int beats_seen = 0;
    int ticks_sent = 0;
    bit gaps_on = 1'b1;
    int stall_left = 0;

    single_wire_sensor_reader_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_req    (start_req),
        .line_level   (line_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive_enable (drive_enable),
        .drive_level  (drive_level),
        .byte_valid   (byte_valid),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .busy_res     (busy_res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int frame_len_of(input logic [swsr_pkg::FRAME_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > swsr_pkg::MAX_FRAME_BYTES)
            return int'(swsr_pkg::MAX_FRAME_BYTES);
        return int'(v);
    endfunction

    // Advance the link by one sample tick and return the result beat it yields.
    function automatic swsr_pkg::result_t next_link_result(input logic req, input logic line);
        swsr_pkg::result_t r;
        r = '0;
        case (link_phase)
            swsr_pkg::PH_IDLE:
                if (req)
                begin
                    link_phase = swsr_pkg::PH_START_LO;
                    link_ticks = TK_W'(1);
                    link_bits  = '0;
                    link_bytes = '0;
                    link_shift = '0;
                end
            swsr_pkg::PH_START_LO:
                if (link_ticks >= link_cfg.start_low_ticks)
                begin
                    link_phase = swsr_pkg::PH_START_HI;
                    link_ticks = TK_W'(1);
                end
                else
                    link_ticks = link_ticks + 1'b1;
            swsr_pkg::PH_START_HI:
                if (link_ticks >= link_cfg.start_high_ticks)
                begin
                    link_phase = swsr_pkg::PH_RESP_A;
                    link_ticks = '0;
                end
                else
                    link_ticks = link_ticks + 1'b1;
            swsr_pkg::PH_RESP_A:
                if (!line)
                    link_phase = swsr_pkg::PH_RESP_B;
            swsr_pkg::PH_RESP_B:
                if (line)
                    link_phase = swsr_pkg::PH_RESP_C;
            swsr_pkg::PH_RESP_C:
                if (!line)
                    link_phase = swsr_pkg::PH_BIT_RISE;
            swsr_pkg::PH_BIT_RISE:
                if (line)
                begin
                    link_phase = swsr_pkg::PH_BIT_WAIT;
                    link_ticks = '0;
                end
            swsr_pkg::PH_BIT_WAIT:
            begin
                link_ticks = link_ticks + 1'b1;
                if (link_ticks >= TK_W'(link_cfg.sample_delay_ticks))
                begin
                    link_shift = {link_shift[BYTE_W-2:0], line};
                    link_bits  = link_bits + 1'b1;
                    link_phase = swsr_pkg::PH_BIT_FALL;
                end
            end
            swsr_pkg::PH_BIT_FALL:
                if (!line)
                begin
                    if (link_bits == '0)
                    begin
                        r.byte_valid = 1'b1;
                        r.data_byte  = link_shift;
                        link_shift   = '0;
                        if (int'(link_bytes) + 1 >= frame_len_of(link_cfg.bytes_per_frame))
                        begin
                            r.last_byte = 1'b1;
                            link_bytes  = '0;
                            link_phase  = swsr_pkg::PH_IDLE;
                        end
                        else
                        begin
                            link_bytes = link_bytes + 1'b1;
                            link_phase = swsr_pkg::PH_BIT_RISE;
                        end
                    end
                    else
                        link_phase = swsr_pkg::PH_BIT_RISE;
                end
            default:
                link_phase = swsr_pkg::PH_IDLE;
        endcase
        r.drive_enable = (link_phase == swsr_pkg::PH_START_LO)
                         || (link_phase == swsr_pkg::PH_START_HI);
        r.drive_level  = (link_phase == swsr_pkg::PH_START_HI);
        r.busy_res     = (link_phase != swsr_pkg::PH_IDLE);
        return r;
    endfunction

    function automatic string show(input swsr_pkg::result_t r);
        return $sformatf("en=%0b lvl=%0b vld=%0b byte=%02h last=%0b busy=%0b",
                         r.drive_enable, r.drive_level, r.byte_valid, r.data_byte,
                         r.last_byte, r.busy_res);
    endfunction

    // start requests during a reading must be ignored
    function automatic logic busy_req(input bit hold);
        if (link_phase == swsr_pkg::PH_IDLE)
            return 1'b0;
        return hold | 1'($urandom_range(0, 1));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(1, 10);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_beat = {drive_enable, drive_level, byte_valid, data_byte, last_byte, busy_res};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d: no result expected, got %s", beats_seen, show(got_beat));
            end
            else
            begin
                want_beat = pending_results.pop_front();
                if (got_beat.drive_enable !== want_beat.drive_enable ||
                    got_beat.drive_level  !== want_beat.drive_level  ||
                    got_beat.byte_valid   !== want_beat.byte_valid   ||
                    got_beat.data_byte    !== want_beat.data_byte    ||
                    got_beat.last_byte    !== want_beat.last_byte    ||
                    got_beat.busy_res     !== want_beat.busy_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: expected %s, got %s", beats_seen,
                                 show(want_beat), show(got_beat));
                end
            end
            beats_seen++;
        end
    end

    task automatic send_tick(input logic req, input logic line);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        start_req  <= req;
        line_level <= line;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(next_link_result(req, line));
        ticks_sent++;
    endtask

    // random line until the reading finishes; no new requests
    task automatic drain_link();
        while (link_phase != swsr_pkg::PH_IDLE)
            send_tick(1'b0, 1'($urandom_range(0, 1)));
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        drain_link();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            swsr_pkg::REG_START_LOW:
                link_cfg.start_low_ticks = data[TK_W-1:0];
            swsr_pkg::REG_START_HIGH:
                link_cfg.start_high_ticks = data[TK_W-1:0];
            swsr_pkg::REG_SAMPLE_DELAY:
                link_cfg.sample_delay_ticks = data[swsr_pkg::DELAY_W-1:0];
            swsr_pkg::REG_FRAME_BYTES:
                link_cfg.bytes_per_frame = data[swsr_pkg::FRAME_W-1:0];
            default: ;
        endcase
    endtask

    // Plays the sensor side of one whole reading: start pulse, response,
    // then every bit of the frame with randomized pulse widths.
    task automatic run_frame(input fill_t fill, input bit hold);
        int d;
        int nbits;
        int h;
        logic level;
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        while (link_phase == swsr_pkg::PH_START_LO || link_phase == swsr_pkg::PH_START_HI)
            send_tick(busy_req(hold), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 3)) send_tick(busy_req(hold), 1'b1);
        repeat ($urandom_range(1, 4)) send_tick(busy_req(hold), 1'b0);
        repeat ($urandom_range(1, 4)) send_tick(busy_req(hold), 1'b1);
        d = (link_cfg.sample_delay_ticks == '0) ? 1 : int'(link_cfg.sample_delay_ticks);
        nbits = BYTE_W * frame_len_of(link_cfg.bytes_per_frame);
        for (int i = 0; i < nbits; i++)
        begin
            repeat ($urandom_range(1, 4)) send_tick(busy_req(hold), 1'b0);
            case (fill)
                FILL_ONES:  level = 1'b1;
                FILL_ZEROS: level = 1'b0;
                default:    level = 1'($urandom_range(0, 1));
            endcase
            if (level)
                repeat (d + $urandom_range(1, 4)) send_tick(busy_req(hold), 1'b1);
            else
            begin
                // short pulse: line must already be low on the sample tick
                h = $urandom_range(1, d);
                repeat (h) send_tick(busy_req(hold), 1'b1);
                repeat (d - h + 1) send_tick(busy_req(hold), 1'b0);
            end
        end
        send_tick(busy_req(hold), 1'b0);
    endtask

    task automatic test_idle_line();
        repeat (12) send_tick(1'b0, 1'($urandom_range(0, 1)));
    endtask

    // short low pulse and a one-byte frame; high pulse and sample delay
    // keep their reset values
    task automatic test_reset_config();
        write_reg(swsr_pkg::REG_START_LOW, DATA_W'(6));
        write_reg(swsr_pkg::REG_FRAME_BYTES, DATA_W'(1));
        run_frame(FILL_RANDOM, 1'b0);
    endtask

    task automatic test_zero_counts();
        write_reg(swsr_pkg::REG_START_LOW, '0);
        write_reg(swsr_pkg::REG_START_HIGH, '0);
        write_reg(swsr_pkg::REG_SAMPLE_DELAY, '0);
        write_reg(swsr_pkg::REG_FRAME_BYTES, '0);
        run_frame(FILL_ONES, 1'b1);
        // restart on the tick right after the last byte
        run_frame(FILL_ZEROS, 1'b1);
    endtask

    task automatic test_frame_clamp();
        write_reg(swsr_pkg::REG_START_LOW, DATA_W'(1));
        write_reg(swsr_pkg::REG_START_HIGH, DATA_W'(1));
        write_reg(swsr_pkg::REG_SAMPLE_DELAY, DATA_W'(1));
        write_reg(swsr_pkg::REG_FRAME_BYTES, DATA_W'(9));
        run_frame(FILL_RANDOM, 1'b1);
    endtask

    task automatic test_unknown_index();
        write_reg(swsr_pkg::REG_FRAME_BYTES, DATA_W'(1));
        for (int i = int'(swsr_pkg::REG_FRAME_BYTES) + 1; i < 2 ** IDX_W; i++)
            write_reg(IDX_W'(i), DATA_W'($urandom));
        run_frame(FILL_RANDOM, 1'b0);
    endtask

    // longer start pulse; upper data bits beyond each register are dropped
    task automatic test_long_pulses();
        write_reg(swsr_pkg::REG_START_LOW, DATA_W'(40));
        write_reg(swsr_pkg::REG_START_HIGH, DATA_W'(24));
        write_reg(swsr_pkg::REG_SAMPLE_DELAY, DATA_W'(16'hFF03));
        write_reg(swsr_pkg::REG_FRAME_BYTES, DATA_W'(16'hFFF1));
        run_frame(FILL_ONES, 1'b0);
    endtask

    // one random register setup followed by one reading or line noise
    task automatic random_round();
        int pick;
        write_reg(swsr_pkg::REG_START_LOW, DATA_W'($urandom_range(0, 24)));
        write_reg(swsr_pkg::REG_START_HIGH, DATA_W'($urandom_range(0, 12)));
        write_reg(swsr_pkg::REG_SAMPLE_DELAY, {8'($urandom), 8'($urandom_range(0, 6))});
        write_reg(swsr_pkg::REG_FRAME_BYTES, {12'($urandom), 4'($urandom_range(0, 9))});
        if ($urandom_range(0, 5) == 0)
            write_reg(IDX_W'($urandom_range(int'(swsr_pkg::REG_FRAME_BYTES) + 1, 15)),
                      DATA_W'($urandom));
        pick = $urandom_range(0, 9);
        if (pick < 7)
            run_frame(FILL_RANDOM, 1'($urandom_range(0, 1)));
        else
        begin
            // broken or garbage line activity, then let it run out
            repeat ($urandom_range(5, 40))
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            drain_link();
        end
        repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_readings();
        while (ticks_sent < 1000)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            random_round();
        end
        // closing stretch runs without random input gaps or output stalls
        gaps_on = 1'b0;
        while (ticks_sent < 1150)
            random_round();
    endtask

    initial
    begin
        link_cfg   = {swsr_pkg::RST_START_LOW, swsr_pkg::RST_START_HIGH,
                      swsr_pkg::RST_SAMPLE_DELAY, swsr_pkg::RST_FRAME_BYTES};
        link_phase = swsr_pkg::PH_IDLE;
        link_ticks = '0;
        link_bits  = '0;
        link_bytes = '0;
        link_shift = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_line();
        test_reset_config();
        test_zero_counts();
        test_frame_clamp();
        test_unknown_index();
        test_long_pulses();
        test_random_readings();

        in_valid <= 1'b0;
        for (int i = 0; i < 1000 && pending_results.size() != 0; i++)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
